@@ sv/moving_average_crossover_tracker_top_assert.svh @@
// ----------------------------------------------------------------------------
// Moving-average crossover tracker assertion macros
// Shorthand for the concurrent checks used by the port checker.
// ----------------------------------------------------------------------------
`ifndef MOVING_AVERAGE_CROSSOVER_TRACKER_TOP_ASSERT_SVH
`define MOVING_AVERAGE_CROSSOVER_TRACKER_TOP_ASSERT_SVH

// same-cycle implication, quiet during reset
`define MACCT_ASSERT_IMPLY(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("macct: same-cycle check failed");

// next-cycle implication, quiet during reset
`define MACCT_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("macct: next-cycle check failed");

`endif

@@ sv/macct_pkg.sv @@
// ----------------------------------------------------------------------------
// Crossover tracker package
// Shared widths, register indexes, command and event codes, stage payload.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package macct_pkg;

   localparam int MAX_WINDOW_DEFAULT = 64;
   localparam int PRICE_BITS         = 32;
   localparam int WINDOW_BITS        = 7;
   localparam int PROFIT_BITS        = 48;
   localparam int CSR_INDEX_BITS     = 8;

   // window register reset values
   localparam logic [WINDOW_BITS-1:0] FAST_RESET = 7'd10;
   localparam logic [WINDOW_BITS-1:0] SLOW_RESET = 7'd30;

   // register indexes
   localparam logic [CSR_INDEX_BITS-1:0] REG_FAST_WINDOW = 8'd0;
   localparam logic [CSR_INDEX_BITS-1:0] REG_SLOW_WINDOW = 8'd1;

   // input commands
   localparam logic CMD_BAR    = 1'b0;
   localparam logic CMD_FINISH = 1'b1;

   // result events
   typedef enum logic [1:0] {
      EV_NONE  = 2'd0,
      EV_OPEN  = 2'd1,
      EV_CLOSE = 2'd2
   } event_type;

   // result tdata layout, lowest bit up
   localparam int RSP_EVENT_LSB  = 0;
   localparam int RSP_LONG_BIT   = RSP_EVENT_LSB + 2;
   localparam int RSP_ENTRY_LSB  = RSP_LONG_BIT + 1;
   localparam int RSP_PROFIT_LSB = RSP_ENTRY_LSB + PRICE_BITS;
   localparam int RSP_READY_BIT  = RSP_PROFIT_LSB + PROFIT_BITS;
   localparam int RSP_FIELD_BITS = RSP_READY_BIT + 1;
   localparam int RSP_TDATA_BITS = ((RSP_FIELD_BITS + 7) / 8) * 8;

   // saturation limits of the profit total
   localparam logic [PROFIT_BITS-1:0] PROFIT_MAX = {1'b0, {(PROFIT_BITS-1){1'b1}}};
   localparam logic [PROFIT_BITS-1:0] PROFIT_MIN = {1'b1, {(PROFIT_BITS-1){1'b0}}};

   // one item as it moves down the pipeline
   typedef struct packed {
      logic                  cmd;
      logic [PRICE_BITS-1:0] price;
      logic                  full_fast;   // fast window was full before this bar
      logic                  full_slow;
      logic                  ready_fast;  // fast window full after this item
      logic                  ready_slow;
      logic                  seen_bar;    // at least one bar before this item
   } item_type;

endpackage

@@ sv/macct_ring.sv @@
// ----------------------------------------------------------------------------
// Crossover tracker price ring
// One write port, two registered read ports; reads return the old contents
// on a same-address write.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module macct_ring #(
   parameter  int DEPTH     = macct_pkg::MAX_WINDOW_DEFAULT,
   parameter  int DATA_BITS = macct_pkg::PRICE_BITS,
   localparam int AW        = $clog2(DEPTH)
) (
   input  logic                 clock,
   input  logic                 wr_en,
   input  logic [AW-1:0]        wr_addr,
   input  logic [DATA_BITS-1:0] wr_data,
   input  logic                 rd_en,
   input  logic [AW-1:0]        rd_addr_a,
   input  logic [AW-1:0]        rd_addr_b,
   output logic [DATA_BITS-1:0] rd_data_a,
   output logic [DATA_BITS-1:0] rd_data_b
);

   logic [DATA_BITS-1:0] mem_ff [DEPTH];
   logic [DATA_BITS-1:0] rd_a_ff;
   logic [DATA_BITS-1:0] rd_b_ff;

   // storage and read-first ports
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_a_ff <= mem_ff[rd_addr_a];
         rd_b_ff <= mem_ff[rd_addr_b];
      end
   end

   assign rd_data_a = rd_a_ff;
   assign rd_data_b = rd_b_ff;

endmodule

@@ sv/macct_window.sv @@
// ----------------------------------------------------------------------------
// Crossover tracker window sums
// Keeps running sums over the newest fast and slow windows, updated per bar
// from the dropped ring entries; resums the ring after a window change.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module macct_window #(
   parameter  int MAX_WINDOW = macct_pkg::MAX_WINDOW_DEFAULT,
   localparam int CW         = $clog2(MAX_WINDOW + 1),
   localparam int PW         = $clog2(MAX_WINDOW),
   localparam int SUMW       = macct_pkg::PRICE_BITS + PW
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic [CW-1:0]                   fast_len,
   input  logic [CW-1:0]                   slow_len,
   input  logic [CW-1:0]                   sample_count,
   input  logic [PW-1:0]                   write_pointer,
   input  logic                            sweep_start,
   input  logic                            p1_valid,
   input  macct_pkg::item_type             p1_item,
   input  logic [macct_pkg::PRICE_BITS-1:0] drop_fast,
   input  logic [macct_pkg::PRICE_BITS-1:0] drop_slow,
   input  logic                            p3_ready,
   output logic                            p2_ready,
   output logic                            p2_valid,
   output macct_pkg::item_type             p2_item,
   output logic [SUMW-1:0]                 fast_sum,
   output logic [SUMW-1:0]                 slow_sum,
   output logic                            busy,
   output logic                            sweep_rd,
   output logic [PW-1:0]                   sweep_addr
);

   import macct_pkg::*;

   typedef enum logic {
      ST_RUN,
      ST_SWEEP
   } state_type;

   state_type       state_ff;
   logic [PW-1:0]   sw_pos_ff;
   logic [CW-1:0]   sw_left_ff;
   logic [CW-1:0]   sw_n_ff;
   logic            pend_ff;
   logic [CW-1:0]   pend_n_ff;
   logic            v2_ff;
   item_type        item2_ff;
   logic [SUMW-1:0] fsum_ff;
   logic [SUMW-1:0] ssum_ff;
   logic [SUMW-1:0] fsum_in;
   logic [SUMW-1:0] ssum_in;
   logic            load2;

   // resum walk goes back from the newest entry
   assign sweep_addr = (sw_pos_ff == '0) ? PW'(MAX_WINDOW - 1) : sw_pos_ff - PW'(1);
   assign sweep_rd   = (state_ff == ST_SWEEP) && (sw_left_ff != '0);
   assign busy       = (state_ff == ST_SWEEP);
   assign p2_ready   = !v2_ff || p3_ready;
   assign load2      = p1_valid && p2_ready;

   // next sums: clear on window change, accumulate during resum, else slide
   always_comb begin
      fsum_in = fsum_ff;
      ssum_in = ssum_ff;
      priority if (sweep_start) begin
         fsum_in = '0;
         ssum_in = '0;
      end else if ((state_ff == ST_SWEEP) && pend_ff) begin
         if (pend_n_ff <= fast_len) begin
            fsum_in = fsum_ff + SUMW'(drop_fast);
         end
         if (pend_n_ff <= slow_len) begin
            ssum_in = ssum_ff + SUMW'(drop_fast);
         end
      end else if (load2 && (p1_item.cmd == CMD_BAR)) begin
         fsum_in = fsum_ff + SUMW'(p1_item.price)
                   - (p1_item.full_fast ? SUMW'(drop_fast) : '0);
         ssum_in = ssum_ff + SUMW'(p1_item.price)
                   - (p1_item.full_slow ? SUMW'(drop_slow) : '0);
      end
   end

   // stage register, sums and resum sequencer
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= ST_RUN;
         sw_pos_ff  <= '0;
         sw_left_ff <= '0;
         sw_n_ff    <= '0;
         pend_ff    <= 1'b0;
         pend_n_ff  <= '0;
         v2_ff      <= 1'b0;
         fsum_ff    <= '0;
         ssum_ff    <= '0;
      end else begin
         fsum_ff <= fsum_in;
         ssum_ff <= ssum_in;
         if (p2_ready) begin
            v2_ff <= p1_valid;
         end
         if (load2) begin
            item2_ff <= p1_item;
         end
         if (sweep_start) begin
            state_ff   <= ST_SWEEP;
            sw_pos_ff  <= write_pointer;
            sw_left_ff <= sample_count;
            sw_n_ff    <= '0;
            pend_ff    <= 1'b0;
         end else begin
            unique case (state_ff)
               ST_RUN: begin
               end
               ST_SWEEP: begin
                  pend_ff <= sweep_rd;
                  if (sweep_rd) begin
                     sw_pos_ff  <= sweep_addr;
                     sw_left_ff <= sw_left_ff - CW'(1);
                     sw_n_ff    <= sw_n_ff + CW'(1);
                     pend_n_ff  <= sw_n_ff + CW'(1);
                  end
                  if (!sweep_rd && !pend_ff) begin
                     state_ff <= ST_RUN;
                  end
               end
               default: begin
                  state_ff <= ST_RUN;
               end
            endcase
         end
      end
   end

   assign p2_valid = v2_ff;
   assign p2_item  = item2_ff;
   assign fast_sum = fsum_ff;
   assign slow_sum = ssum_ff;

endmodule

@@ sv/macct_position.sv @@
// ----------------------------------------------------------------------------
// Crossover tracker position logic
// Cross-multiplies the window sums, then opens or closes the long position,
// books saturating profit and holds the result register.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module macct_position #(
   parameter  int MAX_WINDOW = macct_pkg::MAX_WINDOW_DEFAULT,
   localparam int CW         = $clog2(MAX_WINDOW + 1),
   localparam int PW         = $clog2(MAX_WINDOW),
   localparam int SUMW       = macct_pkg::PRICE_BITS + PW,
   localparam int PRODW      = SUMW + CW
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic [CW-1:0]                    fast_len,
   input  logic [CW-1:0]                    slow_len,
   input  logic                             p2_valid,
   input  macct_pkg::item_type              p2_item,
   input  logic [SUMW-1:0]                  fast_sum,
   input  logic [SUMW-1:0]                  slow_sum,
   input  logic                             rsp_ready,
   output logic                             p3_ready,
   output logic                             rsp_valid,
   output macct_pkg::event_type             rsp_event,
   output logic                             rsp_long,
   output logic [macct_pkg::PRICE_BITS-1:0]  rsp_entry,
   output logic [macct_pkg::PROFIT_BITS-1:0] rsp_profit,
   output logic                             rsp_windows_ready
);

   import macct_pkg::*;

   localparam int GW = PRICE_BITS + 1;
   localparam int TW = PROFIT_BITS + 1;

   // product stage
   logic             v3_ff;
   item_type         item3_ff;
   logic             act3_ff;
   logic             act3_in;
   logic [PRODW-1:0] prod_fast_ff;
   logic [PRODW-1:0] prod_slow_ff;
   logic [PRODW-1:0] prod_fast_in;
   logic [PRODW-1:0] prod_slow_in;

   // position state and result register
   logic                   hold_ff;
   logic                   hold_in;
   logic [PRICE_BITS-1:0]  opened_ff;
   logic [PRICE_BITS-1:0]  opened_in;
   logic [PRICE_BITS-1:0]  last_ff;
   logic [PRICE_BITS-1:0]  last_in;
   logic [PROFIT_BITS-1:0] profit_ff;
   logic [PROFIT_BITS-1:0] profit_in;
   event_type              event_ff;
   event_type              event_in;
   logic                   ready_ff;
   logic                   rsp_valid_ff;

   logic                   out_ready;
   logic                   fast_above;
   logic                   fast_below;
   logic                   take_gain;
   logic [PRICE_BITS-1:0]  gain_price;
   logic [GW-1:0]          gain_diff;
   logic [TW-1:0]          profit_sum;
   logic [PROFIT_BITS-1:0] profit_sat;

   assign out_ready = !rsp_valid_ff || rsp_ready;
   assign p3_ready  = !v3_ff || out_ready;

   // fast_sum/fast_len vs slow_sum/slow_len, compared without division
   assign prod_fast_in = PRODW'(fast_sum) * PRODW'(slow_len);
   assign prod_slow_in = PRODW'(slow_sum) * PRODW'(fast_len);
   assign act3_in      = (p2_item.cmd == CMD_BAR) && p2_item.ready_fast
                         && p2_item.ready_slow && (fast_sum != '0) && (slow_sum != '0);

   assign fast_above = prod_fast_ff > prod_slow_ff;
   assign fast_below = prod_fast_ff < prod_slow_ff;

   // open/close decision
   always_comb begin
      hold_in   = hold_ff;
      opened_in = opened_ff;
      last_in   = last_ff;
      event_in  = EV_NONE;
      take_gain = 1'b0;
      if (item3_ff.cmd == CMD_FINISH) begin
         if (hold_ff && item3_ff.seen_bar) begin
            hold_in   = 1'b0;
            event_in  = EV_CLOSE;
            take_gain = 1'b1;
         end
      end else begin
         last_in = item3_ff.price;
         if (act3_ff && !hold_ff && fast_above) begin
            hold_in   = 1'b1;
            opened_in = item3_ff.price;
            event_in  = EV_OPEN;
         end else if (act3_ff && hold_ff && fast_below) begin
            hold_in   = 1'b0;
            event_in  = EV_CLOSE;
            take_gain = 1'b1;
         end
      end
   end

   // realized gain, saturating at the profit limits
   assign gain_price = (item3_ff.cmd == CMD_FINISH) ? last_ff : item3_ff.price;
   assign gain_diff  = {1'b0, gain_price} - {1'b0, opened_ff};
   assign profit_sum = {profit_ff[PROFIT_BITS-1], profit_ff}
                       + {{(TW-GW){gain_diff[GW-1]}}, gain_diff};
   assign profit_sat = (profit_sum[TW-1] != profit_sum[TW-2])
                       ? (profit_sum[TW-1] ? PROFIT_MIN : PROFIT_MAX)
                       : profit_sum[PROFIT_BITS-1:0];
   assign profit_in  = take_gain ? profit_sat : profit_ff;

   // product stage and result register
   always_ff @(posedge clock) begin
      if (reset) begin
         v3_ff        <= 1'b0;
         rsp_valid_ff <= 1'b0;
         hold_ff      <= 1'b0;
         opened_ff    <= '0;
         last_ff      <= '0;
         profit_ff    <= '0;
      end else begin
         if (p3_ready) begin
            v3_ff <= p2_valid;
         end
         if (p2_valid && p3_ready) begin
            item3_ff     <= p2_item;
            act3_ff      <= act3_in;
            prod_fast_ff <= prod_fast_in;
            prod_slow_ff <= prod_slow_in;
         end
         if (out_ready) begin
            rsp_valid_ff <= v3_ff;
         end
         if (v3_ff && out_ready) begin
            hold_ff   <= hold_in;
            opened_ff <= opened_in;
            last_ff   <= last_in;
            profit_ff <= profit_in;
            event_ff  <= event_in;
            ready_ff  <= item3_ff.ready_fast && item3_ff.ready_slow;
         end
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_event         = event_ff;
   assign rsp_long          = hold_ff;
   assign rsp_entry         = hold_ff ? opened_ff : '0;
   assign rsp_profit        = profit_ff;
   assign rsp_windows_ready = ready_ff;

endmodule

@@ sv/moving_average_crossover_tracker_top.sv @@
// ----------------------------------------------------------------------------
// Moving-average crossover tracker
// Takes one transaction per clock while req_tready is high: a bar close or a
// finish command. Closes go into a MAX_WINDOW-entry ring; the fast and slow
// window sums slide by one add and one subtract per bar, using two ring reads
// issued at accept. Each transaction gives one result after the ring read at
// accept, then the sum update, cross-multiply and position update stages, and
// a new transaction can be accepted every cycle while results drain. A write
// to either window register starts a resum pass over the stored closes, one
// ring read a cycle; req_tready is low for it.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module moving_average_crossover_tracker_top #(
   parameter int MAX_WINDOW = macct_pkg::MAX_WINDOW_DEFAULT
) (
   input  logic                                 clock,
   input  logic                                 reset,
   // input channel
   input  logic                                 req_tvalid,
   output logic                                 req_tready,
   input  logic [macct_pkg::PRICE_BITS-1:0]     req_tdata,  // [31:0] close_price
   input  logic                                 req_tuser,  // [0] command
   // result channel
   output logic                                 rsp_tvalid,
   input  logic                                 rsp_tready,
   // [1:0] event_res, [2] position_long, [34:3] entry_price,
   // [82:35] profit_total, [83] windows_ready, [87:84] zero
   output logic [macct_pkg::RSP_TDATA_BITS-1:0] rsp_tdata,
   // register writes
   input  logic                                 csr_valid,
   output logic                                 csr_ready,
   input  logic [macct_pkg::CSR_INDEX_BITS-1:0] csr_index,
   input  logic [macct_pkg::WINDOW_BITS-1:0]    csr_data
);

   import macct_pkg::*;

   localparam int CW   = $clog2(MAX_WINDOW + 1);
   localparam int PW   = $clog2(MAX_WINDOW);
   localparam int AW   = CW + 1;
   localparam int SUMW = PRICE_BITS + PW;

   logic [WINDOW_BITS-1:0] fast_window_ff;
   logic [WINDOW_BITS-1:0] fast_window_in;
   logic [WINDOW_BITS-1:0] slow_window_ff;
   logic [WINDOW_BITS-1:0] slow_window_in;
   logic [CW-1:0]          fast_len;
   logic [CW-1:0]          slow_len;
   logic [PW-1:0]          wp_ff;
   logic [PW-1:0]          wp_in;
   logic [CW-1:0]          cnt_ff;
   logic [CW-1:0]          cnt_in;
   logic                   v1_ff;
   item_type               item1_ff;
   item_type               item1_in;

   logic                   accept;
   logic                   is_bar;
   logic                   csr_write;
   logic                   sweep_start;
   logic                   p1_ready;
   logic                   p2_ready;
   logic                   p3_ready;
   logic                   busy;
   logic                   sweep_rd;
   logic [PW-1:0]          sweep_addr;
   logic                   rd_en;
   logic [PW-1:0]          rd_addr_a;
   logic [PW-1:0]          fast_addr;
   logic [PW-1:0]          slow_addr;
   logic [PRICE_BITS-1:0]  drop_fast;
   logic [PRICE_BITS-1:0]  drop_slow;

   logic                   p2_valid;
   item_type               p2_item;
   logic [SUMW-1:0]        fast_sum;
   logic [SUMW-1:0]        slow_sum;

   event_type              rsp_event;
   logic                   rsp_long;
   logic [PRICE_BITS-1:0]  rsp_entry;
   logic [PROFIT_BITS-1:0] rsp_profit;
   logic                   rsp_windows_ready;

   // zero acts as one, anything beyond the ring as the ring depth
   function automatic logic [CW-1:0] clamp_window(input logic [WINDOW_BITS-1:0] w);
      if (w == '0) begin
         return CW'(1);
      end else if (32'(w) > 32'(MAX_WINDOW)) begin
         return CW'(MAX_WINDOW);
      end else begin
         return CW'(w);
      end
   endfunction

   // ring slot w places behind the write pointer
   function automatic logic [PW-1:0] back_addr(input logic [PW-1:0] p,
                                               input logic [CW-1:0] w);
      logic [AW-1:0] pe;
      logic [AW-1:0] we;
      pe = AW'(p);
      we = AW'(w);
      if (pe >= we) begin
         return PW'(pe - we);
      end else begin
         return PW'(pe + AW'(MAX_WINDOW) - we);
      end
   endfunction

   // register writes
   assign csr_ready   = 1'b1;
   assign csr_write   = csr_valid && csr_ready;
   assign sweep_start = csr_write
                        && ((csr_index == REG_FAST_WINDOW) || (csr_index == REG_SLOW_WINDOW));
   assign fast_window_in = (csr_write && (csr_index == REG_FAST_WINDOW)) ? csr_data
                                                                         : fast_window_ff;
   assign slow_window_in = (csr_write && (csr_index == REG_SLOW_WINDOW)) ? csr_data
                                                                         : slow_window_ff;
   assign fast_len = clamp_window(fast_window_ff);
   assign slow_len = clamp_window(slow_window_ff);

   // accept and ring bookkeeping
   assign p1_ready   = !v1_ff || p2_ready;
   assign req_tready = p1_ready && !busy;
   assign accept     = req_tvalid && req_tready;
   assign is_bar     = (req_tuser == CMD_BAR);
   assign fast_addr  = back_addr(wp_ff, fast_len);
   assign slow_addr  = back_addr(wp_ff, slow_len);
   assign rd_en      = accept || sweep_rd;
   assign rd_addr_a  = sweep_rd ? sweep_addr : fast_addr;

   always_comb begin
      wp_in  = wp_ff;
      cnt_in = cnt_ff;
      if (accept && is_bar) begin
         wp_in = (wp_ff == PW'(MAX_WINDOW - 1)) ? '0 : wp_ff + PW'(1);
         if (cnt_ff != CW'(MAX_WINDOW)) begin
            cnt_in = cnt_ff + CW'(1);
         end
      end
   end

   // first stage payload
   always_comb begin
      item1_in.cmd        = req_tuser;
      item1_in.price      = req_tdata;
      item1_in.full_fast  = cnt_ff >= fast_len;
      item1_in.full_slow  = cnt_ff >= slow_len;
      item1_in.ready_fast = cnt_in >= fast_len;
      item1_in.ready_slow = cnt_in >= slow_len;
      item1_in.seen_bar   = cnt_ff != '0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fast_window_ff <= FAST_RESET;
         slow_window_ff <= SLOW_RESET;
         wp_ff          <= '0;
         cnt_ff         <= '0;
         v1_ff          <= 1'b0;
      end else begin
         fast_window_ff <= fast_window_in;
         slow_window_ff <= slow_window_in;
         wp_ff          <= wp_in;
         cnt_ff         <= cnt_in;
         if (p1_ready) begin
            v1_ff <= accept;
         end
         if (accept) begin
            item1_ff <= item1_in;
         end
      end
   end

   macct_ring #(
      .DEPTH     (MAX_WINDOW),
      .DATA_BITS (PRICE_BITS)
   ) u_ring (
      .clock     (clock),
      .wr_en     (accept && is_bar),
      .wr_addr   (wp_ff),
      .wr_data   (req_tdata),
      .rd_en     (rd_en),
      .rd_addr_a (rd_addr_a),
      .rd_addr_b (slow_addr),
      .rd_data_a (drop_fast),
      .rd_data_b (drop_slow)
   );

   macct_window #(
      .MAX_WINDOW (MAX_WINDOW)
   ) u_window (
      .clock         (clock),
      .reset         (reset),
      .fast_len      (fast_len),
      .slow_len      (slow_len),
      .sample_count  (cnt_ff),
      .write_pointer (wp_ff),
      .sweep_start   (sweep_start),
      .p1_valid      (v1_ff),
      .p1_item       (item1_ff),
      .drop_fast     (drop_fast),
      .drop_slow     (drop_slow),
      .p3_ready      (p3_ready),
      .p2_ready      (p2_ready),
      .p2_valid      (p2_valid),
      .p2_item       (p2_item),
      .fast_sum      (fast_sum),
      .slow_sum      (slow_sum),
      .busy          (busy),
      .sweep_rd      (sweep_rd),
      .sweep_addr    (sweep_addr)
   );

   macct_position #(
      .MAX_WINDOW (MAX_WINDOW)
   ) u_position (
      .clock             (clock),
      .reset             (reset),
      .fast_len          (fast_len),
      .slow_len          (slow_len),
      .p2_valid          (p2_valid),
      .p2_item           (p2_item),
      .fast_sum          (fast_sum),
      .slow_sum          (slow_sum),
      .rsp_ready         (rsp_tready),
      .p3_ready          (p3_ready),
      .rsp_valid         (rsp_tvalid),
      .rsp_event         (rsp_event),
      .rsp_long          (rsp_long),
      .rsp_entry         (rsp_entry),
      .rsp_profit        (rsp_profit),
      .rsp_windows_ready (rsp_windows_ready)
   );

   // result packing, lowest field first
   assign rsp_tdata = RSP_TDATA_BITS'({rsp_windows_ready, rsp_profit, rsp_entry,
                                       rsp_long, rsp_event});

endmodule

@@ sv/macct_checker.sv @@
// ----------------------------------------------------------------------------
// Crossover tracker port checker
// Watches the result channel of the top level for consistent transactions.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "moving_average_crossover_tracker_top_assert.svh"

module macct_checker (
   input logic                                 clock,
   input logic                                 reset,
   input logic                                 rsp_tvalid,
   input logic                                 rsp_tready,
   input logic [macct_pkg::RSP_TDATA_BITS-1:0] rsp_tdata
);

   import macct_pkg::*;

   logic [1:0]            ev;
   logic                  lng;
   logic [PRICE_BITS-1:0] entry;

   assign ev    = rsp_tdata[RSP_EVENT_LSB +: 2];
   assign lng   = rsp_tdata[RSP_LONG_BIT];
   assign entry = rsp_tdata[RSP_ENTRY_LSB +: PRICE_BITS];

   // a stalled result stays put
   `MACCT_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_tvalid && !rsp_tready, rsp_tvalid && $stable(rsp_tdata))

   // only defined event codes
   `MACCT_ASSERT_IMPLY(a_event_code, clock, reset, rsp_tvalid, ev == EV_NONE || ev == EV_OPEN || ev == EV_CLOSE)

   // an open leaves us long, a close leaves us flat
   `MACCT_ASSERT_IMPLY(a_event_position, clock, reset, rsp_tvalid && ev != EV_NONE, lng == (ev == EV_OPEN))

   // flat results carry no entry price
   `MACCT_ASSERT_IMPLY(a_flat_entry, clock, reset, rsp_tvalid && !lng, entry == '0)

endmodule

bind moving_average_crossover_tracker_top macct_checker u_macct_checker (
   .clock      (clock),
   .reset      (reset),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata)
);
